// ----- hdl/ecs_pkg.sv -----
`default_nettype none

package ecs_pkg;

  localparam int ByteW   = 8;
  localparam int LenW    = 12;
  localparam int PktSeqW = 3;
  localparam int ChunkW  = 8;
  localparam int FrameB  = 8;
  localparam int PosW    = 3;

  // One input word after the input register
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic [LenW-1:0]  packet_length;
    logic             last_byte;
  } item_t;

  // One finished CAN frame
  typedef struct packed {
    logic [PktSeqW-1:0]           packet_seq;
    logic [ChunkW-1:0]            chunk_seq;
    logic [FrameB-1:0][ByteW-1:0] bytes;
    logic                         last_frame;
  } frame_t;

endpackage

`default_nettype wire

// ----- hdl/ethernet_to_can_segmenter.sv -----
`default_nettype none

// Channel   Dir  Word contents
// s_*       in   one packet byte with packet length; tlast marks the last byte
// m_*       out  one CAN frame with sequence tags; tlast marks the last frame
//
// Each byte passes an input register and then the assembly logic, which
// loads the result register when a frame closes: one byte per cycle unless a
// closing byte waits on a stalled m_*; a closed frame leaves from the result register.
// Reset clears the packet counter, the partial frame and both valid flags.
// A stall on m_* holds the frame; bytes that do not close a frame still go in.

module ethernet_to_can_segmenter
  import ecs_pkg::*;
#(
  parameter int MAX_PACKET_BYTES = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,  // data_byte[7:0], packet_length[19:8], zero[23:20]
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [79:0]      m_tdata,  // packet_seq[2:0], chunk_seq[10:3], byte0..byte7
                                     // at [18:11]..[74:67], zero[79:75]
  output logic             m_tlast
);

  item_t  in_item;
  item_t  item;
  logic   item_valid;
  logic   item_take;
  frame_t frame;

  // Unpack the input word
  assign in_item.data_byte     = s_tdata[7:0];
  assign in_item.packet_length = s_tdata[19:8];
  assign in_item.last_byte     = s_tlast;

  ecs_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  ecs_assemble #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_asm (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item        (item),
    .item_take   (item_take),
    .frame_valid (m_tvalid),
    .frame       (frame),
    .frame_ready (m_tready)
  );

  // Pack the output word
  always_comb begin
    m_tdata        = '0;
    m_tdata[2:0]   = frame.packet_seq;
    m_tdata[10:3]  = frame.chunk_seq;
    for (int k = 0; k < FrameB; k++) begin
      m_tdata[11 + 8*k +: 8] = frame.bytes[k];
    end
    m_tlast = frame.last_frame;
  end

endmodule

`default_nettype wire

// ----- hdl/ecs_in_stage.sv -----
`default_nettype none

module ecs_in_stage
  import ecs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  output logic       item_valid,
  output item_t      item,
  input  wire logic  item_take
);

  // Accept a new word when empty or when the held word moves on
  assign in_ready = !item_valid || item_take;

  // Hold the accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ecs_assemble.sv -----
`default_nettype none

module ecs_assemble
  import ecs_pkg::*;
#(
  parameter int MAX_PACKET_BYTES = 2048
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  item_valid,
  input  wire item_t item,
  output logic       item_take,
  output logic       frame_valid,
  output frame_t     frame,
  input  wire logic  frame_ready
);

  localparam logic [15:0] MaxLen = 16'(MAX_PACKET_BYTES);

  logic [PktSeqW-1:0]           pkt_cnt;
  logic [ChunkW-1:0]            chunk_cnt;
  logic [PosW-1:0]              fill;
  logic                         first;
  logic [FrameB-1:0][ByteW-1:0] buffer;

  logic [PosW-1:0]              wr_idx;
  logic                         emit;
  logic [PktSeqW-1:0]           pkt_cnt_next;
  logic                         out_free;
  logic [15:0]                  len_ext;
  logic [15:0]                  len_clip;
  logic [ByteW-1:0]             count;
  frame_t                       frame_next;

  // Frame count byte: 1 + ceil((len-7)/8) reduces to 1 + len/8 for len >= 8
  always_comb begin
    len_ext  = {4'b0, item.packet_length};
    len_clip = (len_ext > MaxLen) ? MaxLen : len_ext;
    if (len_clip <= 16'd7) begin
      count = 8'd1;
    end else begin
      count = 8'(16'd1 + (len_clip >> 3));
    end
  end

  // Place of the new byte and whether it closes the frame
  always_comb begin
    wr_idx       = first ? fill + 3'd1 : fill;
    emit         = item.last_byte || (first ? (fill >= 3'd6) : (fill == 3'd7));
    pkt_cnt_next = (first && fill == '0) ? pkt_cnt + 3'd1 : pkt_cnt;
    out_free     = !frame_valid || frame_ready;
    item_take    = item_valid && (!emit || out_free);
  end

  // Build the outgoing frame from the buffer plus the current byte
  always_comb begin
    frame_next.packet_seq = pkt_cnt_next;
    frame_next.chunk_seq  = chunk_cnt;
    frame_next.last_frame = item.last_byte;
    for (int k = 0; k < FrameB; k++) begin
      frame_next.bytes[k] = (PosW'(k) == wr_idx) ? item.data_byte : buffer[k];
    end
    if (first) begin
      frame_next.bytes[0] = count;
    end
  end

  // Advance packet state and load the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_cnt     <= '0;
      chunk_cnt   <= '0;
      fill        <= '0;
      first       <= 1'b1;
      buffer      <= '0;
      frame_valid <= 1'b0;
    end else begin
      if (item_take && emit) begin
        frame_valid <= 1'b1;
      end else if (frame_ready) begin
        frame_valid <= 1'b0;
      end
      if (item_take) begin
        pkt_cnt <= pkt_cnt_next;
        if (emit) begin
          frame       <= frame_next;
          buffer      <= '0;
          fill        <= '0;
          chunk_cnt   <= item.last_byte ? '0 : chunk_cnt + 8'd1;
          first       <= item.last_byte;
        end else begin
          buffer[wr_idx] <= item.data_byte;
          fill           <= fill + 3'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
module tb;
  import ecs_pkg::*;

  localparam int MaxPktBytes = 2048;
  localparam int RandWords   = 1820;
  localparam int CycleLimit  = 600000;
  localparam int DrainCycles = 16;
  localparam int NumRows     = 23;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;  // data_byte[7:0], packet_length[19:8], zero[23:20]
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;       // packet_seq[2:0], chunk_seq[10:3], byte0..byte7 [74:11]
  logic        m_tlast;

  ethernet_to_can_segmenter u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Segmenter state as the frames should see it
  logic [PktSeqW-1:0] pkt_seq_q      = '0;
  logic [ChunkW-1:0]  chunk_idx      = '0;
  logic [PosW-1:0]    fill_cnt       = '0;
  logic               in_first_frame = 1'b1;
  logic [ByteW-1:0]   frame_bytes [FrameB] = '{default: '0};

  frame_t pending_frames [$];
  int     mismatch_count = 0;
  int     cycle_cnt      = 0;
  int     words_sent     = 0;
  int     burst_left     = 1;
  int     rdy_mode       = 0;
  int     rdy_left       = 0;

  // Directed words; typed rows carry the frame the word must close
  typedef struct {
    logic [7:0]  data;
    logic [11:0] length;
    logic        last;
    bit          typed;
    logic [2:0]  seq;
    logic [7:0]  chunk;
    logic [63:0] payload;  // byte7..byte0
  } stim_row_t;

  stim_row_t dir_rows [NumRows] = '{
    // one-byte packet, length 1
    '{8'hFF, 12'd1, 1'b1, 1'b1, 3'd1, 8'd0, 64'h0000_0000_0000_FF01},
    // length 0 still counts one frame
    '{8'h00, 12'd0, 1'b1, 1'b1, 3'd2, 8'd0, 64'h0000_0000_0000_0001},
    // short packet whose length claims two frames
    '{8'hA0, 12'd12, 1'b0, 1'b0, 3'd0, 8'd0, 64'h0},
    '{8'hB1, 12'd12, 1'b0, 1'b0, 3'd0, 8'd0, 64'h0},
    '{8'hC2, 12'd12, 1'b1, 1'b1, 3'd3, 8'd0, 64'h0000_0000_C2B1_A002},
    // ten bytes: full first frame, padded second frame
    '{8'h80, 12'd10, 1'b0, 1'b0, 3'd0, 8'd0, 64'h0},
    '{8'h81, 12'd10, 1'b0, 1'b0, 3'd0, 8'd0, 64'h0},
    '{8'h82, 12'd10, 1'b0, 1'b0, 3'd0, 8'd0, 64'h0},
    '{8'h83, 12'd10, 1'b0, 1'b0, 3'd0, 8'd0, 64'h0},
    '{8'h84, 12'd10, 1'b0, 1'b0, 3'd0, 8'd0, 64'h0},
    '{8'h85, 12'd10, 1'b0, 1'b0, 3'd0, 8'd0, 64'h0},
    '{8'h86, 12'd10, 1'b0, 1'b1, 3'd4, 8'd0, 64'h8685_8483_8281_8002},
    '{8'h87, 12'd10, 1'b0, 1'b0, 3'd0, 8'd0, 64'h0},
    '{8'h88, 12'd10, 1'b0, 1'b0, 3'd0, 8'd0, 64'h0},
    '{8'h89, 12'd10, 1'b1, 1'b1, 3'd4, 8'd1, 64'h0000_0000_0089_8887},
    // eight bytes with the largest length field, clamped and wrapped count
    '{8'h5A, 12'd4095, 1'b0, 1'b0, 3'd0, 8'd0, 64'h0},
    '{8'hA5, 12'd4095, 1'b0, 1'b0, 3'd0, 8'd0, 64'h0},
    '{8'h3C, 12'd4095, 1'b0, 1'b0, 3'd0, 8'd0, 64'h0},
    '{8'hC3, 12'd4095, 1'b0, 1'b0, 3'd0, 8'd0, 64'h0},
    '{8'h0F, 12'd4095, 1'b0, 1'b0, 3'd0, 8'd0, 64'h0},
    '{8'hF0, 12'd4095, 1'b0, 1'b0, 3'd0, 8'd0, 64'h0},
    '{8'h55, 12'd4095, 1'b0, 1'b0, 3'd0, 8'd0, 64'h0},
    '{8'hAA, 12'd4095, 1'b1, 1'b0, 3'd0, 8'd0, 64'h0}
  };

  // Frame count carried in byte0 of the first frame
  function automatic logic [7:0] count_byte(input logic [11:0] len);
    int unsigned clamped;
    int unsigned rest;
    int unsigned frames;
    clamped = 32'(len);
    if (clamped > MaxPktBytes) clamped = MaxPktBytes;
    if (clamped <= 7) return 8'd1;
    rest   = clamped - 7;
    frames = 1 + rest / 8;
    if (rest % 8 != 0) frames++;
    return frames[7:0];
  endfunction

  // Place one byte into the frame being built; hand back the frame it closes
  task automatic segment_byte(input logic [7:0] d, input logic [11:0] len,
                              input logic lst, output bit closes, output frame_t fr);
    fr = '0;
    if (in_first_frame && fill_cnt == '0) pkt_seq_q = pkt_seq_q + 3'd1;
    if (in_first_frame) begin
      frame_bytes[fill_cnt + 3'd1] = d;
      closes = lst || fill_cnt >= 3'd6;
      if (closes) frame_bytes[0] = count_byte(len);
    end else begin
      frame_bytes[fill_cnt] = d;
      closes = lst || fill_cnt == 3'd7;
    end
    if (!closes) begin
      fill_cnt = fill_cnt + 3'd1;
      return;
    end
    fr.packet_seq = pkt_seq_q;
    fr.chunk_seq  = chunk_idx;
    for (int k = 0; k < FrameB; k++) fr.bytes[k] = frame_bytes[k];
    fr.last_frame = lst;
    frame_bytes = '{default: '0};
    fill_cnt    = '0;
    if (lst) begin
      chunk_idx      = '0;
      in_first_frame = 1'b1;
    end else begin
      chunk_idx      = chunk_idx + 8'd1;
      in_first_frame = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what);
    if (mismatch_count < 50) $display("MISMATCH cycle %0d: %s", cycle_cnt, what);
    mismatch_count++;
  endtask

  // Present one word, wait for it to be taken, then maybe pause the burst
  task automatic send_word(input logic [7:0] d, input logic [11:0] len, input logic lst,
                           input bit typed, input frame_t want);
    bit     closes;
    frame_t fr;
    int     gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, len, d};
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    segment_byte(d, len, lst, closes, fr);
    if (closes) pending_frames.push_back(typed ? want : fr);
    words_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 200)
                                               : $urandom_range(1, 12);
      gap = $urandom_range(1, 6);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // One packet of random bytes; a noisy packet also varies the length per byte
  task automatic send_packet(input int nbytes, input logic [11:0] len, input bit noisy);
    logic [11:0] this_len;
    for (int i = 0; i < nbytes; i++) begin
      this_len = len;
      if (noisy && $urandom_range(0, 3) == 0) this_len = 12'($urandom_range(0, 4095));
      send_word(8'($urandom_range(0, 255)), this_len, i == nbytes - 1, 1'b0, '0);
    end
  endtask

  // Compare one accepted frame with the oldest expectation
  task automatic check_frame();
    frame_t want;
    if (pending_frames.size() == 0) begin
      report_mismatch($sformatf("unexpected frame %h", m_tdata));
      return;
    end
    want = pending_frames.pop_front();
    if (m_tdata[2:0] !== want.packet_seq)
      report_mismatch($sformatf("packet_seq got %0d want %0d", m_tdata[2:0], want.packet_seq));
    if (m_tdata[10:3] !== want.chunk_seq)
      report_mismatch($sformatf("chunk_seq got %0d want %0d", m_tdata[10:3], want.chunk_seq));
    for (int k = 0; k < FrameB; k++)
      if (m_tdata[11 + 8*k +: 8] !== want.bytes[k])
        report_mismatch($sformatf("byte%0d got %h want %h (packet %0d chunk %0d)", k,
                                  m_tdata[11 + 8*k +: 8], want.bytes[k],
                                  want.packet_seq, want.chunk_seq));
    if (m_tlast !== want.last_frame)
      report_mismatch($sformatf("last_frame got %b want %b", m_tlast, want.last_frame));
  endtask

  // Monitor the frame stream
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_frame();
  end

  // Receiver: switch between ready, random, sparse and stalled stretches
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (rdy_left == 0) begin
        rdy_mode = $urandom_range(0, 3);
        rdy_left = $urandom_range(8, 80);
      end else begin
        rdy_left--;
      end
      case (rdy_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= 1'b0;
      endcase
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    frame_t want;
    int     pick;
    int     nbytes;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    for (int r = 0; r < NumRows; r++) begin
      want            = '0;
      want.packet_seq = dir_rows[r].seq;
      want.chunk_seq  = dir_rows[r].chunk;
      want.bytes      = dir_rows[r].payload;
      want.last_frame = dir_rows[r].last;
      send_word(dir_rows[r].data, dir_rows[r].length, dir_rows[r].last,
                dir_rows[r].typed, want);
    end

    // Random packets: mostly well formed, some with noisy length fields
    words_sent = 0;
    while (words_sent < RandWords) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        if (pick < 55)      nbytes = $urandom_range(1, 24);
        else if (pick < 75) nbytes = $urandom_range(25, 120);
        else                nbytes = $urandom_range(121, 400);
        send_packet(nbytes, 12'(nbytes), 1'b0);
      end else begin
        send_packet($urandom_range(1, 40), 12'($urandom_range(0, 4095)), 1'b1);
      end
    end
    s_tvalid <= 1'b0;

    // Drain
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/ecs_pkg.sv
hdl/ecs_in_stage.sv
hdl/ecs_assemble.sv
hdl/ethernet_to_can_segmenter.sv
bench/tb.sv
